@@ hdl/toeq_pkg.sv @@
// ----------------------------------------------------------------------------
// toeq_pkg
// Shared constants, codes and types of the time-ordered event queue.
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned StampW = 32;
  localparam int unsigned TagW   = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_INS_FULL  = 2'd2
  } status_e;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    logic                     insert;
    logic                     pop;
    logic signed [StampW-1:0] stamp;
    logic        [TagW-1:0]   tag;
  } cell_ctrl_t;

endpackage

@@ hdl/time_ordered_event_queue.sv @@
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// Sorted queue of delayed actions built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// One command is taken per clock cycle; busy_o stays low. Every cell compares
// its entry with the incoming stamp in parallel and shifts in the same cycle,
// so the result appears on the result ports in the cycle after start_i, marked
// by done_o for that one cycle only: the receiver must take it then, as it
// cannot stall the block. fill_level_o gives the count after the command;
// entries with equal stamps leave in the order they arrived.
module time_ordered_event_queue
  import toeq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic        [1:0]        op_i,
  input  logic signed [StampW-1:0] stamp_i,
  input  logic        [TagW-1:0]   action_tag_i,
  output logic                     done_o,
  output logic                     due_before_o,
  output logic signed [StampW-1:0] popped_stamp_o,
  output logic        [TagW-1:0]   popped_tag_o,
  output logic        [1:0]        status_o,
  output logic        [4:0]        fill_level_o
);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  logic            due_q, due_d;
  logic signed [StampW-1:0] pstamp_q, pstamp_d;
  logic        [TagW-1:0]   ptag_q, ptag_d;
  status_e         status_q, status_d;

  logic                     accept;
  logic                     is_full, is_empty;
  cell_ctrl_t               ctrl;
  logic [Depth-1:0]         place;
  logic signed [StampW-1:0] stamps [Depth];
  logic        [TagW-1:0]   tags   [Depth];

  assign busy_o   = 1'b0;
  assign accept   = start_i;
  assign is_full  = (count_q == CntW'(Depth));
  assign is_empty = (count_q == '0);

  always_comb begin
    ctrl        = '0;
    ctrl.stamp  = stamp_i;
    ctrl.tag    = action_tag_i;
    count_d     = count_q;
    due_d       = 1'b0;
    pstamp_d    = '0;
    ptag_d      = '0;
    status_d    = ST_OK;
    unique case (op_i)
      OP_INSERT: begin
        if (is_full) begin
          status_d = ST_INS_FULL;
        end else begin
          ctrl.insert = accept;
          count_d     = count_q + 1'b1;
        end
      end
      OP_QUERY: begin
        due_d = !is_empty && (stamps[0] < stamp_i);
      end
      OP_POP: begin
        if (is_empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          ctrl.pop = accept;
          pstamp_d = stamps[0];
          ptag_d   = tags[0];
          count_d  = count_q - 1'b1;
        end
      end
      default: begin
        // unused code: no operation
      end
    endcase
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                     left_place;
    logic signed [StampW-1:0] left_stamp, right_stamp;
    logic        [TagW-1:0]   left_tag, right_tag;

    if (i == 0) begin : g_head
      assign left_place = 1'b0;
      assign left_stamp = stamp_i;
      assign left_tag   = action_tag_i;
    end else begin : g_body
      assign left_place = place[i-1];
      assign left_stamp = stamps[i-1];
      assign left_tag   = tags[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      // hold the last slot on a pop; it falls outside the count anyway
      assign right_stamp = stamps[i];
      assign right_tag   = tags[i];
    end else begin : g_inner
      assign right_stamp = stamps[i+1];
      assign right_tag   = tags[i+1];
    end

    toeq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (CntW'(i) < count_q),
      .left_place_i  (left_place),
      .left_stamp_i  (left_stamp),
      .left_tag_i    (left_tag),
      .right_stamp_i (right_stamp),
      .right_tag_i   (right_tag),
      .place_o       (place[i]),
      .stamp_o       (stamps[i]),
      .tag_o         (tags[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      due_q    <= due_d;
      pstamp_q <= pstamp_d;
      ptag_q   <= ptag_d;
      status_q <= status_d;
    end
  end

  assign done_o         = done_q;
  assign due_before_o   = due_q;
  assign popped_stamp_o = pstamp_q;
  assign popped_tag_o   = ptag_q;
  assign status_o       = status_q;
  assign fill_level_o   = 5'(count_q);

endmodule

@@ hdl/toeq_cell.sv @@
// ----------------------------------------------------------------------------
// toeq_cell
// One slot of the sorted chain: holds an entry, compares it with the new
// stamp and takes its next value from itself, its neighbours or the input.
// ----------------------------------------------------------------------------
module toeq_cell
  import toeq_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     occ_i,
  input  logic                     left_place_i,
  input  logic signed [StampW-1:0] left_stamp_i,
  input  logic        [TagW-1:0]   left_tag_i,
  input  logic signed [StampW-1:0] right_stamp_i,
  input  logic        [TagW-1:0]   right_tag_i,
  output logic                     place_o,
  output logic signed [StampW-1:0] stamp_o,
  output logic        [TagW-1:0]   tag_o
);

  logic signed [StampW-1:0] stamp_q, stamp_d;
  logic        [TagW-1:0]   tag_q, tag_d;

  // New entry belongs here or earlier: slot is free or holds a later stamp.
  assign place_o = !occ_i || (stamp_q > ctrl_i.stamp);

  always_comb begin
    stamp_d = stamp_q;
    tag_d   = tag_q;
    if (ctrl_i.insert) begin
      if (left_place_i) begin
        stamp_d = left_stamp_i;
        tag_d   = left_tag_i;
      end else if (place_o) begin
        stamp_d = ctrl_i.stamp;
        tag_d   = ctrl_i.tag;
      end
    end else if (ctrl_i.pop) begin
      stamp_d = right_stamp_i;
      tag_d   = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    tag_q   <= tag_d;
  end

  assign stamp_o = stamp_q;
  assign tag_o   = tag_q;

endmodule

@@ tb/sv/toeq_checker.sv @@
// ----------------------------------------------------------------------------
// toeq_checker
// Watches the command and result sides of the event queue, predicts and checks.
// ----------------------------------------------------------------------------
// Keeps its own sorted copy of the held entries. Every accepted command is
// applied to that copy, and the outcome is queued. Every result strobe is
// compared field by field with the oldest queued outcome.
module toeq_checker
  import toeq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic        [1:0]        op_i,
  input  logic signed [StampW-1:0] stamp_i,
  input  logic        [TagW-1:0]   action_tag_i,
  input  logic                     done_i,
  input  logic                     due_before_i,
  input  logic signed [StampW-1:0] popped_stamp_i,
  input  logic        [TagW-1:0]   popped_tag_i,
  input  logic        [1:0]        status_i,
  input  logic        [4:0]        fill_level_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       full_refusals_o,
  output int                       empty_pops_o,
  output int                       deepest_fill_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]               op;
    logic                     due;
    logic signed [StampW-1:0] stamp;
    logic        [TagW-1:0]   tag;
    logic        [1:0]        status;
    logic        [4:0]        fill;
  } outcome_t;

  logic signed [StampW-1:0] held_stamp [Depth];
  logic        [TagW-1:0]   held_tag   [Depth];
  int unsigned              held_count;

  outcome_t awaited_outcomes[$];
  int       n_fail;
  int       n_full;
  int       n_empty;
  int       n_deepest;

  // Apply one command to the sorted copy and give the result it must produce.
  task automatic apply_command(input logic [1:0] op, input logic signed [StampW-1:0] stamp,
                               input logic [TagW-1:0] tag, output outcome_t res);
    int unsigned slot;
    res    = '0;
    res.op = op;
    case (op)
      OP_INSERT: begin
        if (held_count >= Depth) begin
          res.status = ST_INS_FULL;
        end else begin
          // Land after every entry that is not later, so equal stamps keep arrival order.
          slot = 0;
          while (slot < held_count && held_stamp[slot] <= stamp) slot++;
          for (int unsigned i = held_count; i > slot; i--) begin
            held_stamp[i] = held_stamp[i-1];
            held_tag[i]   = held_tag[i-1];
          end
          held_stamp[slot] = stamp;
          held_tag[slot]   = tag;
          held_count++;
        end
      end
      OP_QUERY: begin
        res.due = (held_count > 0) && (held_stamp[0] < stamp);
      end
      OP_POP: begin
        if (held_count == 0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          res.stamp = held_stamp[0];
          res.tag   = held_tag[0];
          for (int unsigned i = 1; i < held_count; i++) begin
            held_stamp[i-1] = held_stamp[i];
            held_tag[i-1]   = held_tag[i];
          end
          held_count--;
        end
      end
      default: ;
    endcase
    res.fill = 5'(held_count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      held_count = 0;
      awaited_outcomes.delete();
      n_fail    = 0;
      n_full    = 0;
      n_empty   = 0;
      n_deepest = 0;
    end else begin
      // Check the result first: it belongs to a transfer of an earlier edge.
      if (done_i) begin
        got = '{op: 2'd0, due: due_before_i, stamp: popped_stamp_i, tag: popped_tag_i,
                status: status_i, fill: fill_level_i};
        if (awaited_outcomes.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: result with no command outstanding: %s %0b %0d %h %0d %0d",
                     $realtime, "due/stamp/tag/status/fill", got.due, got.stamp, got.tag,
                     got.status, got.fill);
          n_fail++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.due !== want.due || got.stamp !== want.stamp || got.tag !== want.tag ||
              got.status !== want.status || got.fill !== want.fill) begin
            if (n_fail < 10) begin
              $display("%0t: mismatch on op %0d: expected due %0b stamp %0d tag %h",
                       $realtime, want.op, want.due, want.stamp, want.tag);
              $display("%0t:   expected status %0d fill %0d",
                       $realtime, want.status, want.fill);
              $display("%0t:   got due %0b stamp %0d tag %h status %0d fill %0d",
                       $realtime, got.due, got.stamp, got.tag, got.status, got.fill);
            end
            n_fail++;
          end
        end
      end
      if (start_i && !busy_i) begin
        apply_command(op_i, stamp_i, action_tag_i, want);
        awaited_outcomes.insert(awaited_outcomes.size(), want);
        if (want.status == ST_INS_FULL) n_full++;
        if (want.status == ST_POP_EMPTY) n_empty++;
        if (int'(want.fill) > n_deepest) n_deepest = int'(want.fill);
      end
    end
    fail_count_o    <= n_fail;
    pending_o       <= awaited_outcomes.size();
    full_refusals_o <= n_full;
    empty_pops_o    <= n_empty;
    deepest_fill_o  <= n_deepest;
  end

endmodule

@@ tb/sv/time_ordered_event_queue_tb.sv @@
// ----------------------------------------------------------------------------
// time_ordered_event_queue_tb
// Command stimulus and verdict for the time-ordered event queue.
// ----------------------------------------------------------------------------
// A directed opening covers the empty and extreme cases, then trend-driven
// random traffic fills the queue to the brim and drains it dry in turn, under
// several sender idling phases. The checker beside the block does the scoring.
module time_ordered_event_queue_tb;
  import toeq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int         PhaseLen = 420;

  typedef enum int {TrendFill, TrendDrain, TrendMix} trend_e;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     start_i      = 1'b0;
  logic        [1:0]        op_i         = OP_INSERT;
  logic signed [StampW-1:0] stamp_i      = '0;
  logic        [TagW-1:0]   action_tag_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic                     due_before_o;
  logic signed [StampW-1:0] popped_stamp_o;
  logic        [TagW-1:0]   popped_tag_o;
  logic        [1:0]        status_o;
  logic        [4:0]        fill_level_o;

  int fail_count;
  int pending;
  int full_refusals;
  int empty_pops;
  int deepest_fill;
  int n_insert;
  int n_query;
  int n_pop;
  int n_unused;

  time_ordered_event_queue dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .stamp_i, .action_tag_i,
    .done_o, .due_before_o, .popped_stamp_o, .popped_tag_o, .status_o, .fill_level_o
  );

  toeq_checker checker_inst (
    .clk_i, .rst_ni, .start_i,
    .busy_i         (busy_o),
    .op_i, .stamp_i, .action_tag_i,
    .done_i         (done_o),
    .due_before_i   (due_before_o),
    .popped_stamp_i (popped_stamp_o),
    .popped_tag_i   (popped_tag_o),
    .status_i       (status_o),
    .fill_level_i   (fill_level_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .full_refusals_o(full_refusals),
    .empty_pops_o   (empty_pops),
    .deepest_fill_o (deepest_fill)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Present one command, hold it until transferred, then idle at random.
  task automatic issue(input logic [1:0] op, input logic signed [StampW-1:0] stamp,
                       input logic [TagW-1:0] tag, input int unsigned idle_pct);
    start_i      <= 1'b1;
    op_i         <= op;
    stamp_i      <= stamp;
    action_tag_i <= tag;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (op)
      OP_INSERT: n_insert++;
      OP_QUERY:  n_query++;
      OP_POP:    n_pop++;
      default:   n_unused++;
    endcase
    while ($urandom_range(99) < idle_pct) begin
      start_i      <= 1'b0;
      op_i         <= 2'($urandom);
      stamp_i      <= $urandom;
      action_tag_i <= 16'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Hold off until every outstanding result has come back, with a cap.
  task automatic wait_for_results();
    int guard;
    guard   = 0;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && guard < 200) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic logic signed [StampW-1:0] pick_stamp();
    case ($urandom_range(9))
      0:       return {1'b1, {(StampW-1){1'b0}}};
      1:       return {1'b0, {(StampW-1){1'b1}}};
      2, 3, 4: return $signed(StampW'($urandom_range(16))) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_op(input trend_e trend);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return OpUnused;
    case (trend)
      TrendFill:  return roll < 70 ? OP_INSERT : roll < 85 ? OP_QUERY : OP_POP;
      TrendDrain: return roll < 15 ? OP_INSERT : roll < 35 ? OP_QUERY : OP_POP;
      default:    return roll < 40 ? OP_INSERT : roll < 65 ? OP_QUERY : OP_POP;
    endcase
  endfunction

  initial begin
    int unsigned idle_by_phase[4];
    trend_e      trend;
    int          trend_left;
    idle_by_phase = '{0, 55, 0, 29};
    trend         = TrendMix;
    trend_left    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, unused code, extreme stamps and tags, equal-stamp ordering.
    issue(OP_POP,   '0,            16'h0000, 0);
    issue(OP_QUERY, 32'sh7fffffff, 16'hffff, 0);
    issue(OpUnused, 32'sh7fffffff, 16'hffff, 0);
    issue(OP_INSERT, 32'sh7fffffff, 16'hffff, 0);
    issue(OP_INSERT, 32'sh80000000, 16'h0000, 0);
    issue(OP_INSERT, 32'sh00000000, 16'h0001, 0);
    issue(OP_INSERT, 32'sh00000000, 16'h0002, 0);
    issue(OP_INSERT, -32'sd1,       16'h0003, 0);
    issue(OP_INSERT, 32'sh80000000, 16'h0004, 0);
    issue(OP_QUERY, 32'sh80000000, 16'h0000, 0);
    issue(OP_QUERY, 32'sh80000001, 16'h0000, 0);
    issue(OpUnused, '0,            16'h0000, 0);
    repeat (6) issue(OP_POP, '0, 16'h0000, 0);
    issue(OP_POP,   '0,            16'h0000, 0);
    issue(OP_QUERY, 32'sh80000000, 16'h0000, 0);
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      for (int k = 0; k < PhaseLen; k++) begin
        if (trend_left == 0) begin
          trend      = trend_e'($urandom_range(2));
          trend_left = $urandom_range(8, 40);
        end
        trend_left--;
        issue(pick_op(trend), pick_stamp(), 16'($urandom), idle_by_phase[phase]);
      end
      wait_for_results();
    end

    wait_for_results();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d inserts, %0d queries, %0d pops and %0d unused codes.",
             n_insert, n_query, n_pop, n_unused);
    $display("Queue reached %0d entries, refused %0d inserts when full, %0d pops when empty.",
             deepest_fill, full_refusals, empty_pops);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
